// File: rtl/alphabet_order_topological_sort_defines.svh
// assertion macros for the alphabet order sorter
`ifndef ALPHABET_ORDER_TOPOLOGICAL_SORT_DEFINES_SVH
`define ALPHABET_ORDER_TOPOLOGICAL_SORT_DEFINES_SVH

`ifndef SYNTHESIS

`define AOT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define AOT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define AOT_ASSERT(lbl, prop, msg)

`define AOT_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// File: rtl/aot_pkg.sv
// shared types and constants of the alphabet order sorter
`default_nettype none
package aot_pkg;

    localparam int LETTER_W = 5;

    typedef logic [LETTER_W-1:0] letter_t;

    typedef struct packed {
        letter_t letter;
        logic    name_end;
        logic    list_end;
    } item_t;

    typedef struct packed {
        letter_t order_letter;
        logic    impossible;
        logic    last;
    } result_t;

    // queued request with its classification
    typedef struct packed {
        item_t item;
        logic  out_of_range;
    } entry_t;

    // control from the edge unit to the sorter
    typedef struct packed {
        logic    edge_wr;
        letter_t edge_src;
        letter_t edge_dst;
        logic    start;
        logic    failed;
    } edge_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_ROOT,
        S_DEQ,
        S_SCAN,
        S_DONE,
        S_EMIT
    } sort_state_t;

endpackage
`default_nettype wire

// File: rtl/aot_stream_if.sv
// valid/ready stream channel
`default_nettype none
interface aot_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/aot_front.sv
// input request queue with letter range check
`default_nettype none
module aot_front #(
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    aot_stream_if.sink          item,
    output logic                q_valid,
    output aot_pkg::entry_t     q_entry,
    input  wire logic           q_pop
);
    import aot_pkg::*;

    entry_t     ent_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign item.ready = (cnt_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign q_valid    = (cnt_reg != 2'd0);
    assign q_entry    = ent_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg].item         <= item.data;
            ent_reg[wptr_reg].out_of_range <=
                ({1'b0, item.data.letter} >= (LETTER_W+1)'(ALPHABET_SIZE));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (q_pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule
`default_nettype wire

// File: rtl/aot_edge.sv
// name comparison, previous-name memory and precedence edge extraction
`default_nettype none
module aot_edge #(
    parameter int ALPHABET_SIZE   = 26,
    parameter int MAX_NAME_LENGTH = 128
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire aot_pkg::entry_t   q_entry,
    output logic                   q_pop,
    input  wire logic              busy,
    output aot_pkg::edge_ctl_t     ctl
);
    import aot_pkg::*;

    localparam int PW    = $clog2(MAX_NAME_LENGTH + 1);
    localparam int AW    = (MAX_NAME_LENGTH > 1) ? $clog2(MAX_NAME_LENGTH) : 1;
    localparam int DEPTH = 2 ** AW;

    letter_t       name_mem [DEPTH];
    letter_t       rd_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [PW-1:0] plen_reg;
    logic          havep_reg;
    logic          diff_reg;
    logic          failed_reg;

    logic          at_max;
    logic          differ;
    logic          ends;
    logic [PW-1:0] pos_inc;
    logic          diff_upd;
    logic          fail_upd;
    logic          wr_en;
    logic [AW-1:0] raddr;

    assign q_pop  = q_valid && !busy;
    assign at_max = (pos_reg >= PW'(MAX_NAME_LENGTH));
    assign differ = havep_reg && !diff_reg && (pos_reg < plen_reg) && !at_max
                    && (rd_reg != q_entry.item.letter);
    assign ends     = q_entry.item.name_end || q_entry.item.list_end;
    assign pos_inc  = at_max ? pos_reg : pos_reg + PW'(1);
    assign diff_upd = diff_reg || differ;
    // fails on out-of-range letter, overlong name or strict prefix
    assign fail_upd = failed_reg || q_entry.out_of_range || at_max
                      || (ends && havep_reg && !diff_upd && (pos_inc < plen_reg));
    assign wr_en    = q_pop && !at_max;

    always_comb
    begin
        pos_next = pos_reg;
        if (q_pop)
            pos_next = ends ? '0 : pos_inc;
    end

    assign raddr = pos_next[AW-1:0];

    always_comb
    begin
        ctl.edge_wr  = q_pop && differ && !q_entry.out_of_range
                       && ({1'b0, rd_reg} < (LETTER_W+1)'(ALPHABET_SIZE));
        ctl.edge_src = rd_reg;
        ctl.edge_dst = q_entry.item.letter;
        ctl.start    = q_pop && q_entry.item.list_end;
        ctl.failed   = fail_upd;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            name_mem[pos_reg[AW-1:0]] <= q_entry.item.letter;
        // write-first bypass keeps the read in step with the position
        if (wr_en && (pos_reg[AW-1:0] == raddr))
            rd_reg <= q_entry.item.letter;
        else
            rd_reg <= name_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            plen_reg   <= '0;
            havep_reg  <= 1'b0;
            diff_reg   <= 1'b0;
            failed_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            pos_reg <= pos_next;
            if (q_entry.item.list_end)
            begin
                plen_reg   <= '0;
                havep_reg  <= 1'b0;
                diff_reg   <= 1'b0;
                failed_reg <= 1'b0;
            end
            else if (ends)
            begin
                plen_reg   <= pos_inc;
                havep_reg  <= 1'b1;
                diff_reg   <= 1'b0;
                failed_reg <= fail_upd;
            end
            else
            begin
                diff_reg   <= diff_upd;
                failed_reg <= fail_upd;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/aot_sort.sv
// precedence matrix, kahn sort sequencer and result register
`default_nettype none
`include "alphabet_order_topological_sort_defines.svh"
module aot_sort #(
    parameter int ALPHABET_SIZE = 26
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire aot_pkg::edge_ctl_t ctl,
    output logic                    busy,
    aot_stream_if.source            result
);
    import aot_pkg::*;

    localparam int IW = $clog2(ALPHABET_SIZE);
    localparam int CW = $clog2(ALPHABET_SIZE + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ALPHABET_SIZE - 1);

    sort_state_t             state_reg;
    sort_state_t             state_next;
    logic [ALPHABET_SIZE-1:0] rows_reg [ALPHABET_SIZE];
    logic [CW-1:0]            pending_reg [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] placed_reg;
    logic [IW-1:0]            queue_reg [ALPHABET_SIZE];
    logic [IW-1:0]            obuf_reg [ALPHABET_SIZE];
    logic [CW-1:0]            head_reg;
    logic [CW-1:0]            tail_reg;
    logic [CW-1:0]            oc_reg;
    logic [IW-1:0]            idx_reg;
    logic [IW-1:0]            v_reg;
    logic [IW-1:0]            a_reg;
    logic [IW-1:0]            k_reg;
    logic                     fail_reg;
    logic                     res_valid_reg;
    result_t                  res_data_reg;

    logic slot_free;
    logic emit;
    logic emit_last;
    logic root_ok;
    logic succ_hit;
    logic place_succ;

    assign slot_free  = !res_valid_reg || result.ready;
    assign root_ok    = (pending_reg[idx_reg] == '0) && !placed_reg[idx_reg];
    assign succ_hit   = rows_reg[a_reg][v_reg] && (pending_reg[v_reg] != '0);
    assign place_succ = succ_hit && (pending_reg[v_reg] == CW'(1))
                        && !placed_reg[v_reg] && (tail_reg < CW'(ALPHABET_SIZE));
    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (ctl.start)
                    state_next = ctl.failed ? S_DONE : S_COUNT;
            S_COUNT:
                if (idx_reg == LAST_IDX)
                    state_next = S_ROOT;
            S_ROOT:
                if (root_ok)
                    state_next = S_DEQ;
                else if (idx_reg == LAST_IDX)
                    state_next = S_DONE;
            S_DEQ:
                if (head_reg < tail_reg)
                    state_next = S_SCAN;
                else if (idx_reg == LAST_IDX)
                    state_next = S_DONE;
                else
                    state_next = S_ROOT;
            S_SCAN:
                if (v_reg == LAST_IDX)
                    state_next = S_DEQ;
            S_DONE:
                state_next = S_EMIT;
            S_EMIT:
                if (emit && emit_last)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = 1'b1;
        emit      = 1'b0;
        emit_last = fail_reg || (k_reg == LAST_IDX);
        unique case (state_reg)
            S_IDLE:  busy = 1'b0;
            S_EMIT:  emit = slot_free;
            default: busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            placed_reg    <= '0;
            oc_reg        <= '0;
            fail_reg      <= 1'b0;
            for (int i = 0; i < ALPHABET_SIZE; i++)
                rows_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (ctl.edge_wr)
                        rows_reg[ctl.edge_src[IW-1:0]][ctl.edge_dst[IW-1:0]] <= 1'b1;
                    fail_reg   <= ctl.failed;
                    placed_reg <= '0;
                    oc_reg     <= '0;
                end
                S_ROOT:
                    if (root_ok)
                    begin
                        placed_reg[idx_reg]      <= 1'b1;
                        obuf_reg[oc_reg[IW-1:0]] <= idx_reg;
                        oc_reg                   <= oc_reg + CW'(1);
                    end
                S_SCAN:
                    if (place_succ)
                    begin
                        placed_reg[v_reg]        <= 1'b1;
                        obuf_reg[oc_reg[IW-1:0]] <= v_reg;
                        oc_reg                   <= oc_reg + CW'(1);
                    end
                S_DONE:
                    fail_reg <= fail_reg || (oc_reg != CW'(ALPHABET_SIZE));
                S_EMIT:
                    // last result clears the graph for the next list
                    if (emit && emit_last)
                    begin
                        placed_reg <= '0;
                        for (int i = 0; i < ALPHABET_SIZE; i++)
                            rows_reg[i] <= '0;
                    end
                default:
                    fail_reg <= fail_reg;
            endcase
        end
    end

    // datapath without reset
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_data_reg.order_letter <= fail_reg ? '0 : LETTER_W'(obuf_reg[k_reg]);
            res_data_reg.impossible   <= fail_reg;
            res_data_reg.last         <= emit_last;
            k_reg                     <= k_reg + IW'(1);
        end
        case (state_reg)
            S_IDLE:
            begin
                idx_reg <= '0;
                k_reg   <= '0;
                for (int i = 0; i < ALPHABET_SIZE; i++)
                    pending_reg[i] <= '0;
            end
            S_COUNT:
            begin
                for (int i = 0; i < ALPHABET_SIZE; i++)
                    pending_reg[i] <= pending_reg[i] + CW'(rows_reg[idx_reg][i]);
                idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + IW'(1);
            end
            S_ROOT:
                if (root_ok)
                begin
                    queue_reg[0] <= idx_reg;
                    head_reg     <= '0;
                    tail_reg     <= CW'(1);
                end
                else if (idx_reg != LAST_IDX)
                    idx_reg <= idx_reg + IW'(1);
            S_DEQ:
                if (head_reg < tail_reg)
                begin
                    a_reg    <= queue_reg[head_reg[IW-1:0]];
                    head_reg <= head_reg + CW'(1);
                    v_reg    <= '0;
                end
                else if (idx_reg != LAST_IDX)
                    idx_reg <= idx_reg + IW'(1);
            S_SCAN:
            begin
                if (succ_hit)
                    pending_reg[v_reg] <= pending_reg[v_reg] - CW'(1);
                if (place_succ)
                begin
                    queue_reg[tail_reg[IW-1:0]] <= v_reg;
                    tail_reg                    <= tail_reg + CW'(1);
                end
                v_reg <= v_reg + IW'(1);
            end
            default:
            begin
            end
        endcase
    end

    `AOT_ASSERT(a_start_idle, ctl.start |-> (state_reg == S_IDLE), "list end taken while sorting")
    `AOT_ASSERT(a_oc_range, oc_reg <= CW'(ALPHABET_SIZE), "order count overflow")
    `AOT_ASSERT(a_queue_order, (state_reg == S_SCAN) |-> (head_reg <= tail_reg), "queue head past tail")
    `AOT_ASSERT_NEXT(a_emit_valid, emit, res_valid_reg, "result lost on load")

endmodule
`default_nettype wire

// File: rtl/alphabet_order_topological_sort.sv
// Alphabet order sorter: names stream in one letter per cycle, while the
// sorter is idle, through a two-entry queue; each letter is compared with
// the same position of the previous name, which is held in a memory of
// MAX_NAME_LENGTH entries with a registered read, and the first difference
// sets one bit of an ALPHABET_SIZE-square precedence matrix. The letter
// that carries list_end starts a Kahn sort, during which no letter is
// taken: it counts the predecessors of each letter row by row, probes the
// letters in order for roots, drains the queue of each root and scans the
// row of every placed letter; then the ALPHABET_SIZE ordered letters, or
// one impossible result, leave one per cycle through an output register
// while the receiver is ready. The matrix is cleared with the last result.
`default_nettype none
module alphabet_order_topological_sort #(
    parameter int ALPHABET_SIZE   = 26,
    parameter int MAX_NAME_LENGTH = 128
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    aot_stream_if.sink   item,
    aot_stream_if.source result
);
    import aot_pkg::*;

    logic      q_valid;
    entry_t    q_entry;
    logic      q_pop;
    logic      busy;
    edge_ctl_t ctl;

    aot_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    aot_edge #(
        .ALPHABET_SIZE   (ALPHABET_SIZE),
        .MAX_NAME_LENGTH (MAX_NAME_LENGTH)
    ) u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .busy    (busy),
        .ctl     (ctl)
    );

    aot_sort #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_sort (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .busy   (busy),
        .result (result)
    );

endmodule
`default_nettype wire

// File: tb/sv/alphabet_order_checker.sv
// checker: predicts the derived alphabet order and compares every result
`default_nettype none
module alphabet_order_checker
    import aot_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    input  wire logic    item_ready,
    input  wire item_t   item_data,
    input  wire logic    result_valid,
    input  wire logic    result_ready,
    input  wire result_t result_data,
    output int           mismatches,
    output int           pending_results,
    output int           lists_sorted,
    output int           lists_impossible
);
    localparam int NLET = 26;
    localparam int MAXLEN = 128;

    logic [4:0]      prev_name [MAXLEN];
    int              prev_len;
    int              pos;
    logic            have_prev;
    logic            diff_seen;
    logic            list_bad;
    logic [NLET-1:0] succ [NLET];
    result_t         order_q [$];

    // kahn's sort with roots in letter order, each root's queue drained first
    function automatic void sort_list();
        int      indeg [NLET];
        int      fifo [NLET];
        int      head;
        int      tail;
        int      a;
        int      cnt;
        logic [NLET-1:0] done;
        result_t r;
        result_t outs [$];
        done = '0;
        cnt = 0;
        for (int v = 0; v < NLET; v++)
        begin
            indeg[v] = 0;
            for (int u = 0; u < NLET; u++)
                if (succ[u][v])
                    indeg[v]++;
        end
        for (int root = 0; root < NLET; root++)
        begin
            if (indeg[root] != 0 || done[root])
                continue;
            head = 0;
            tail = 0;
            done[root] = 1'b1;
            fifo[tail++] = root;
            r = '{order_letter: 5'(root), impossible: 1'b0, last: 1'b0};
            outs.insert(outs.size(), r);
            while (head < tail)
            begin
                a = fifo[head++];
                for (int v = 0; v < NLET; v++)
                begin
                    if (!succ[a][v] || indeg[v] == 0)
                        continue;
                    indeg[v]--;
                    if (indeg[v] == 0 && !done[v] && tail < NLET)
                    begin
                        done[v] = 1'b1;
                        fifo[tail++] = v;
                        r = '{order_letter: 5'(v), impossible: 1'b0, last: 1'b0};
                        outs.insert(outs.size(), r);
                    end
                end
            end
        end
        cnt = outs.size();
        if (list_bad || cnt != NLET)
        begin
            r = '{order_letter: '0, impossible: 1'b1, last: 1'b1};
            order_q.insert(order_q.size(), r);
            lists_impossible++;
        end
        else
        begin
            outs[NLET-1].last = 1'b1;
            foreach (outs[k])
                order_q.insert(order_q.size(), outs[k]);
            lists_sorted++;
        end
    endfunction

    function automatic void take_letter(item_t it);
        int ltr;
        ltr = it.letter;
        if (ltr >= NLET)
            list_bad = 1'b1;
        if (pos >= MAXLEN)
            list_bad = 1'b1;
        else
        begin
            if (have_prev && !diff_seen && pos < prev_len && prev_name[pos] != it.letter)
            begin
                diff_seen = 1'b1;
                if (ltr < NLET && prev_name[pos] < NLET)
                    succ[prev_name[pos]][ltr] = 1'b1;
            end
            prev_name[pos] = it.letter;
            pos++;
        end
        if (it.name_end || it.list_end)
        begin
            // a name that stops inside the previous one is a strict prefix
            if (have_prev && !diff_seen && pos < prev_len)
                list_bad = 1'b1;
            prev_len = pos;
            pos = 0;
            have_prev = 1'b1;
            diff_seen = 1'b0;
        end
        if (it.list_end)
        begin
            sort_list();
            prev_len = 0;
            have_prev = 1'b0;
            list_bad = 1'b0;
            foreach (succ[u])
                succ[u] = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            prev_len = 0;
            pos = 0;
            have_prev = 1'b0;
            diff_seen = 1'b0;
            list_bad = 1'b0;
            foreach (succ[u])
                succ[u] = '0;
            order_q.delete();
            mismatches = 0;
            pending_results = 0;
            lists_sorted = 0;
            lists_impossible = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (order_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result letter=%0d impossible=%0b last=%0b",
                                 result_data.order_letter, result_data.impossible,
                                 result_data.last);
                end
                else
                begin
                    want = order_q.pop_front();
                    // letter is meaningless in the impossible result
                    if (want.impossible != result_data.impossible
                        || want.last != result_data.last
                        || (!want.impossible && want.order_letter != result_data.order_letter))
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     want.order_letter, want.impossible, want.last,
                                     result_data.order_letter, result_data.impossible,
                                     result_data.last);
                    end
                end
            end
            if (item_valid && item_ready)
                take_letter(item_data);
            pending_results = order_q.size();
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// top of the sorter testbench: stimulus, receiver stalls and verdict
`default_nettype none
module testbench;
    import aot_pkg::*;

    localparam int NLET = 26;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending_results;
    int   lists_sorted;
    int   lists_impossible;
    int   items_sent;
    int   idle_cycles;
    logic stimulus_done;
    logic holdoff_req;
    logic holdoff_done;

    aot_stream_if #(.payload_t(item_t))   item ();
    aot_stream_if #(.payload_t(result_t)) result ();

    alphabet_order_topological_sort DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    alphabet_order_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item.valid),
        .item_ready       (item.ready),
        .item_data        (item.data),
        .result_valid     (result.valid),
        .result_ready     (result.ready),
        .result_data      (result.data),
        .mismatches       (mismatches),
        .pending_results  (pending_results),
        .lists_sorted     (lists_sorted),
        .lists_impossible (lists_impossible)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // send one letter, with a random gap before it
    task automatic send_letter(input int ltr, input bit nend, input bit lend);
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid <= 1'b1;
        item.data <= '{letter: 5'(ltr), name_end: nend, list_end: lend};
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_name(input int name [$], input bit lend);
        foreach (name[k])
            send_letter(name[k], k == name.size() - 1, lend && k == name.size() - 1);
    endtask

    // names built from a hidden random permutation, so the list is consistent
    task automatic send_sorted_list(input int count, input int maxlen);
        int perm [NLET];
        int tmp;
        int j;
        int lists [$][$];
        int nm [$];
        int cmp;
        for (int k = 0; k < NLET; k++)
            perm[k] = k;
        for (int k = NLET - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = perm[k];
            perm[k] = perm[j];
            perm[j] = tmp;
        end
        for (int n = 0; n < count; n++)
        begin
            nm.delete();
            repeat ($urandom_range(1, maxlen))
                nm.insert(nm.size(), $urandom_range(0, 7));
            lists.insert(lists.size(), nm);
        end
        // insertion sort by rank under the permutation
        for (int a = 1; a < lists.size(); a++)
            for (int b = a; b > 0; b--)
            begin
                cmp = 0;
                for (int k = 0; k < lists[b].size() && k < lists[b-1].size() && cmp == 0; k++)
                    if (lists[b][k] != lists[b-1][k])
                        cmp = perm[lists[b][k]] < perm[lists[b-1][k]] ? -1 : 1;
                if (cmp == 0)
                    cmp = lists[b].size() < lists[b-1].size() ? -1 : 0;
                if (cmp >= 0)
                    break;
                nm = lists[b];
                lists[b] = lists[b-1];
                lists[b-1] = nm;
            end
        foreach (lists[n])
            send_name(lists[n], n == lists.size() - 1);
    endtask

    task automatic send_random_list();
        int count;
        int nm [$];
        count = $urandom_range(1, 5);
        for (int n = 0; n < count; n++)
        begin
            nm.delete();
            repeat ($urandom_range(1, 4))
                nm.insert(nm.size(), $urandom_range(0, 10) == 0 ? $urandom_range(0, 31)
                                                                : $urandom_range(0, 25));
            send_name(nm, n == count - 1);
        end
    endtask

    task automatic wait_drained();
        item.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // receiver: random stalls, one long hold-off while lists pile up
    initial
    begin
        int gap;
        result.ready = 1'b0;
        holdoff_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (holdoff_req && !holdoff_done)
            begin
                result.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                holdoff_done = 1'b1;
            end
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 2) == 0)
                gap = 0;
            if (gap > 0)
            begin
                result.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int nm [$];
        items_sent = 0;
        stimulus_done = 1'b0;
        holdoff_req = 1'b0;
        item.valid = 1'b0;
        item.data = '0;
        @(posedge rst_n);
        @(posedge clk);
        // full chain a<b<...<z through neighboring two-letter names
        for (int k = 0; k < NLET; k++)
        begin
            nm = '{0, k};
            send_name(nm, k == NLET - 1);
        end
        wait_drained();
        // equal names then a longer name in one list: no edges
        nm = '{25, 25};
        send_name(nm, 1'b0);
        send_name(nm, 1'b0);
        nm = '{25, 25, 0};
        send_name(nm, 1'b1);
        wait_drained();
        // strict prefix
        nm = '{3, 4, 5};
        send_name(nm, 1'b0);
        nm = '{3, 4};
        send_name(nm, 1'b1);
        // cycle a<b, b<a
        nm = '{0};
        send_name(nm, 1'b0);
        nm = '{1};
        send_name(nm, 1'b0);
        nm = '{0};
        send_name(nm, 1'b1);
        // out of range letter
        nm = '{31, 30};
        send_name(nm, 1'b1);
        wait_drained();
        // too long name: 130 letters
        for (int k = 0; k < 130; k++)
            send_letter(k % 26, 1'b0, k == 129);
        wait_drained();
        // long receiver hold-off while several lists are offered
        holdoff_req = 1'b1;
        repeat (4)
            send_random_list();
        wait_drained();
        while (items_sent < 310)
        begin
            if ($urandom_range(0, 2) == 0)
                send_random_list();
            else
                send_sorted_list($urandom_range(2, 8), 4);
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        item.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if (!rst_n || (item.valid && item.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        fork
            begin
                wait (stimulus_done);
                while (pending_results != 0)
                    @(posedge clk);
                repeat (1000) @(posedge clk);
                $display("run covered %0d letters, %0d sorted lists, %0d impossible lists",
                         items_sent, lists_sorted, lists_impossible);
                if (mismatches == 0 && pending_results == 0)
                    $display("== PASS ==");
                else
                    $display("== FAIL ==");
                $finish;
            end
            begin
                wait (idle_cycles >= STALL_LIMIT);
                $display("watchdog expired with %0d results outstanding", pending_results);
                $display("== FAIL ==");
                $finish;
            end
        join
    end
endmodule
`default_nettype wire
